// ===== hdl/gnre_pkg.sv =====
package gnre_pkg;

  typedef enum logic [2:0] {
    CMD_WR_EDGE  = 3'd0,
    CMD_WR_LABEL = 3'd1,
    CMD_MOVE     = 3'd2,
    CMD_SCORE    = 3'd3,
    CMD_READ     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVER = 2'd1,
    ST_OOR  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_REN_RD,
    S_REN_WR,
    S_ROT_RD,
    S_ROT_WR,
    S_PCLR,
    S_REB_RD,
    S_REB_CNT,
    S_REB_WR,
    S_SC_RD,
    S_SC_ACC,
    S_DONE
  } state_t;

  localparam int unsigned SCORE_MAX = 2097151;

endpackage

// ===== hdl/gnre_ram.sv =====
module gnre_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/graph_node_relocation_engine_top.sv =====
// Command engine over a placed graph held in block memories. start is taken
// only while busy is low; exactly one result per command appears for one
// cycle with done high, and the receiver cannot stall it. After reset a
// clearing pass empties both edge stores and the fan-in counts, with busy
// high. A move walks the successor list of every row to renumber it,
// rotates the rows and labels between the two positions, then clears and
// rebuilds the predecessor store; a score walks the successor and
// predecessor lists of every row of the range. Each store has one read
// port and one write port, so these walks visit one slot at a time.
module graph_node_relocation_engine_top #(
  parameter int MAX_POSITIONS = 256,
  parameter int MAX_OUT       = 8,
  parameter int MAX_IN        = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [7:0]  row,
  input  logic [2:0]  slot,
  input  logic [7:0]  target,
  input  logic        empty_slot,
  input  logic [7:0]  label,
  input  logic [7:0]  pos_a,
  input  logic [7:0]  pos_b,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [20:0] score_sum,
  output logic [7:0]  edge_target,
  output logic        edge_empty,
  output logic [7:0]  row_label
);

  localparam int PW = (MAX_POSITIONS > 256) ? 8 : $clog2(MAX_POSITIONS);
  localparam int NP = (MAX_POSITIONS > 256) ? 256 : MAX_POSITIONS;
  localparam int OW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int IW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
  localparam int JW = (OW > IW) ? OW : IW;
  localparam int SAW = PW + OW;
  localparam int PAW = PW + IW;
  localparam int XW = (SAW > PAW) ? SAW : PAW;
  localparam int CW = $clog2(MAX_IN + 1);
  localparam int SDEPTH = NP * (2 ** OW);
  localparam int PDEPTH = NP * (2 ** IW);

  gnre_pkg::state_t state, state_next;

  logic [8:0]     num_positions;
  logic [8:0]     n_eff;
  logic [2:0]     cmd_q;
  logic [PW-1:0]  row_q, pa_q, pb_q, hi_q;
  logic [7:0]     label_q;
  logic [PW-1:0]  ri;       // row walker
  logic [JW-1:0]  sj;       // slot walker
  logic [8:0]     rsrc;     // rotate source row
  logic [8:0]     rdst;
  logic [SAW-1:0] sa_ptr;
  logic [8:0]     saved [MAX_OUT];
  logic [7:0]     saved_label;
  logic           lab_phase;
  logic           over;
  logic [20:0]    sum;
  logic [1:0]     st_res;
  logic [8:0]     edge_q;
  logic [XW-1:0]  clr_ptr;
  logic [7:0]     rd_tgt;
  logic           rd_empty;
  logic [7:0]     rd_label;

  // memory ports
  logic           s_we, p_we, l_we, f_we;
  logic [SAW-1:0] s_wa, s_ra;
  logic [8:0]     s_wd, s_rd;
  logic [PAW-1:0] p_wa, p_ra;
  logic [8:0]     p_wd, p_rd;
  logic [PW-1:0]  l_wa, l_ra, f_wa, f_ra;
  logic [7:0]     l_wd, l_rd;
  logic [CW-1:0]  f_wd, f_rd;

  gnre_ram #(.WIDTH(9), .DEPTH(SDEPTH)) u_succ (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  gnre_ram #(.WIDTH(9), .DEPTH(PDEPTH)) u_pred (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  gnre_ram #(.WIDTH(8), .DEPTH(NP)) u_label (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
  gnre_ram #(.WIDTH(CW), .DEPTH(NP)) u_fanin (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

  always_comb begin
    n_eff = num_positions;
    if (n_eff == 9'd0) n_eff = 9'd1;
    if (n_eff > 9'(NP)) n_eff = 9'(NP);
  end

  function automatic logic [SAW-1:0] saddr(input logic [PW-1:0] r, input logic [OW-1:0] s);
    return {r, s};
  endfunction

  logic last_slot, last_row;
  assign last_slot = (32'(sj) == MAX_OUT - 1);
  assign last_row  = ({1'b0, ri} == n_eff - 9'd1);

  // renumbered successor value
  logic [8:0] ren_v;
  always_comb begin
    ren_v = s_rd;
    if (s_rd[PW-1:0] == pa_q && s_rd[8:PW] == '0) ren_v = {1'b0, 8'(pb_q)};
    else if (pa_q < pb_q && s_rd > {1'b0, 8'(pa_q)} && s_rd <= {1'b0, 8'(pb_q)})
      ren_v = s_rd - 9'd1;
    else if (pb_q < pa_q && s_rd >= {1'b0, 8'(pb_q)} && s_rd < {1'b0, 8'(pa_q)})
      ren_v = s_rd + 9'd1;
  end

  // score walk: successor slots then predecessor slots for each row
  logic [8:0] sc_v;
  logic [21:0] sc_add;
  logic [8:0] sc_d;
  always_comb begin
    sc_v = lab_phase ? p_rd : s_rd;
    sc_d = (sc_v > {1'b0, 8'(ri)}) ? sc_v - {1'b0, 8'(ri)} : {1'b0, 8'(ri)} - sc_v;
    sc_add = {1'b0, sum} + 22'(sc_d);
  end

  logic sc_end_list;
  assign sc_end_list = sc_v[8] || (lab_phase ? (32'(sj) == MAX_IN - 1) : last_slot);

  logic in_range_ok;
  always_comb begin
    in_range_ok = 1'b1;
    unique case (cmd) inside
      gnre_pkg::CMD_WR_EDGE: in_range_ok = ({1'b0, row} < n_eff) && (32'(slot) < MAX_OUT)
                                           && (empty_slot || {1'b0, target} < n_eff);
      gnre_pkg::CMD_WR_LABEL: in_range_ok = {1'b0, row} < n_eff;
      gnre_pkg::CMD_MOVE, gnre_pkg::CMD_SCORE:
        in_range_ok = ({1'b0, pos_a} < n_eff) && ({1'b0, pos_b} < n_eff);
      gnre_pkg::CMD_READ: in_range_ok = ({1'b0, row} < n_eff) && (32'(slot) < MAX_OUT);
      default: in_range_ok = 1'b1;
    endcase
  end

  logic accept;
  assign accept = start && !busy;
  assign busy = (state != gnre_pkg::S_IDLE);
  assign cfg_ready = (state == gnre_pkg::S_IDLE);

  logic rot_last;
  assign rot_last = (rdst[PW-1:0] == pb_q);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gnre_pkg::S_CLEAR: if (&clr_ptr) state_next = gnre_pkg::S_IDLE;
      gnre_pkg::S_IDLE: if (accept) begin
        if (!in_range_ok) state_next = gnre_pkg::S_DONE;
        else begin
          unique case (cmd)
            gnre_pkg::CMD_READ:  state_next = gnre_pkg::S_READ;
            gnre_pkg::CMD_MOVE:  state_next = gnre_pkg::S_REN_RD;
            gnre_pkg::CMD_SCORE: state_next = gnre_pkg::S_SC_RD;
            default:             state_next = gnre_pkg::S_DONE;
          endcase
        end
      end
      gnre_pkg::S_READ: state_next = gnre_pkg::S_DONE;
      gnre_pkg::S_REN_RD: state_next = gnre_pkg::S_REN_WR;
      gnre_pkg::S_REN_WR:
        if (s_rd[8] || last_slot) begin
          if (last_row) state_next = gnre_pkg::S_ROT_RD;
          else state_next = gnre_pkg::S_REN_RD;
        end else state_next = gnre_pkg::S_REN_RD;
      gnre_pkg::S_ROT_RD: state_next = gnre_pkg::S_ROT_WR;
      gnre_pkg::S_ROT_WR:
        if (lab_phase && rot_last && 32'(sa_ptr[OW-1:0]) == MAX_OUT - 1)
          state_next = gnre_pkg::S_PCLR;
        else state_next = gnre_pkg::S_ROT_RD;
      gnre_pkg::S_PCLR: if (&clr_ptr) state_next = gnre_pkg::S_REB_RD;
      gnre_pkg::S_REB_RD: state_next = gnre_pkg::S_REB_CNT;
      gnre_pkg::S_REB_CNT:
        if (s_rd[8]) state_next = last_row ? gnre_pkg::S_DONE : gnre_pkg::S_REB_RD;
        else if (s_rd >= n_eff)
          state_next = (last_slot && last_row) ? gnre_pkg::S_DONE : gnre_pkg::S_REB_RD;
        else state_next = gnre_pkg::S_REB_WR;
      gnre_pkg::S_REB_WR:
        state_next = (last_slot && last_row) ? gnre_pkg::S_DONE : gnre_pkg::S_REB_RD;
      gnre_pkg::S_SC_RD: state_next = gnre_pkg::S_SC_ACC;
      gnre_pkg::S_SC_ACC: begin
        // finish after the last row's predecessor list
        state_next = gnre_pkg::S_SC_RD;
        if (lab_phase && sc_end_list && ri == hi_q) state_next = gnre_pkg::S_DONE;
      end
      gnre_pkg::S_DONE: state_next = gnre_pkg::S_IDLE;
      default: state_next = gnre_pkg::S_IDLE;
    endcase
  end

  // memory access
  logic [PW-1:0] rot_src_r;
  assign rot_src_r = rsrc[PW-1:0];
  logic [IW-1:0] cnt_slot;
  assign cnt_slot = IW'(f_rd);
  logic [IW-1:0] sj_in;
  assign sj_in = IW'(sj);

  always_comb begin
    s_we = 1'b0; s_wa = saddr(ri, OW'(sj)); s_wd = ren_v; s_ra = saddr(ri, OW'(sj));
    p_we = 1'b0; p_wa = PAW'(clr_ptr); p_wd = 9'h100; p_ra = {ri, sj_in};
    l_we = 1'b0; l_wa = row_q; l_wd = label_q; l_ra = row_q;
    f_we = 1'b0; f_wa = clr_ptr[XW-1 -: PW]; f_wd = '0; f_ra = PW'(edge_q);
    unique case (state)
      gnre_pkg::S_CLEAR: begin
        s_we = 1'b1; s_wa = SAW'(clr_ptr); s_wd = 9'h100;
        p_we = 1'b1;
        f_we = 1'b1;
      end
      gnre_pkg::S_IDLE: begin
        s_ra = saddr(PW'(row), OW'(slot));
        l_ra = PW'(row);
        if (accept && in_range_ok && cmd == gnre_pkg::CMD_WR_EDGE) begin
          s_we = 1'b1; s_wa = saddr(PW'(row), OW'(slot));
          s_wd = empty_slot ? 9'h100 : {1'b0, target};
        end
        if (accept && in_range_ok && cmd == gnre_pkg::CMD_WR_LABEL) begin
          l_we = 1'b1; l_wa = PW'(row); l_wd = label;
        end
      end
      gnre_pkg::S_REN_WR: s_we = !s_rd[8];
      gnre_pkg::S_ROT_RD: begin
        s_ra = sa_ptr;
        l_ra = rot_src_r;
      end
      gnre_pkg::S_ROT_WR: begin
        s_we = lab_phase; s_wa = saddr(rdst[PW-1:0], sa_ptr[OW-1:0]);
        s_wd = rot_last ? saved[sa_ptr[OW-1:0]] : s_rd;
        l_we = lab_phase; l_wa = rdst[PW-1:0]; l_wd = rot_last ? saved_label : l_rd;
      end
      gnre_pkg::S_PCLR: begin p_we = 1'b1; f_we = 1'b1; end
      gnre_pkg::S_REB_CNT: f_ra = s_rd[PW-1:0];
      gnre_pkg::S_REB_WR: begin
        if (32'(f_rd) < MAX_IN) begin
          p_we = 1'b1; p_wa = {PW'(edge_q), cnt_slot}; p_wd = {1'b0, 8'(ri)};
          f_we = 1'b1; f_wa = PW'(edge_q); f_wd = f_rd + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gnre_pkg::S_CLEAR;
      num_positions <= 9'd256;
      clr_ptr <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == gnre_pkg::S_DONE);
      if (cfg_valid && cfg_ready) num_positions <= cfg_data;
      if (state == gnre_pkg::S_CLEAR || state == gnre_pkg::S_PCLR) clr_ptr <= clr_ptr + 1'b1;
      else clr_ptr <= '0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      gnre_pkg::S_IDLE: begin
        cmd_q <= cmd; row_q <= PW'(row); label_q <= label;
        pa_q <= PW'(pos_a); pb_q <= PW'(pos_b);
        hi_q <= PW'((pos_a < pos_b) ? pos_b : pos_a);
        ri <= '0; sj <= '0; over <= 1'b0; sum <= '0; lab_phase <= 1'b0;
        st_res <= in_range_ok ? gnre_pkg::ST_OK : gnre_pkg::ST_OOR;
        if (accept && in_range_ok && cmd == gnre_pkg::CMD_SCORE)
          ri <= PW'((pos_a < pos_b) ? pos_a : pos_b);
        rsrc <= {1'b0, pos_a}; rdst <= {1'b0, pos_a};
        sa_ptr <= saddr(PW'(pos_a), '0);
      end
      gnre_pkg::S_READ: begin
        rd_tgt <= s_rd[8] ? 8'd0 : s_rd[7:0];
        rd_empty <= s_rd[8];
        rd_label <= l_rd;
      end
      gnre_pkg::S_REN_WR: begin
        if (s_rd[8] || last_slot) begin
          sj <= '0;
          ri <= ri + 1'b1;
          if (last_row) begin
            ri <= '0;
          end
        end else sj <= sj + 1'b1;
      end
      gnre_pkg::S_ROT_WR: begin
        // first pass saves the source row, second pass shifts rows toward it
        if (!lab_phase) begin
          saved[sa_ptr[OW-1:0]] <= s_rd;
          saved_label <= l_rd;
          if (32'(sa_ptr[OW-1:0]) == MAX_OUT - 1) begin
            lab_phase <= 1'b1;
            rdst <= {1'b0, 8'(pa_q)};
            rsrc <= (pa_q < pb_q) ? {1'b0, 8'(pa_q)} + 9'd1 :
                    (pa_q > pb_q) ? {1'b0, 8'(pa_q)} - 9'd1 : {1'b0, 8'(pa_q)};
            sa_ptr <= saddr((pa_q < pb_q) ? pa_q + 1'b1 :
                            (pa_q > pb_q) ? pa_q - 1'b1 : pa_q, '0);
          end else sa_ptr <= sa_ptr + 1'b1;
        end else if (32'(sa_ptr[OW-1:0]) == MAX_OUT - 1) begin
          rdst <= rsrc;
          rsrc <= (pa_q < pb_q) ? rsrc + 9'd1 : rsrc - 9'd1;
          sa_ptr <= saddr((pa_q < pb_q) ? rot_src_r + 1'b1 : rot_src_r - 1'b1, '0);
          if (rot_last) begin ri <= '0; sj <= '0; end
        end else sa_ptr <= sa_ptr + 1'b1;
      end
      gnre_pkg::S_REB_RD: ;
      gnre_pkg::S_REB_CNT: begin
        edge_q <= s_rd;
        if (s_rd[8] || s_rd >= n_eff) begin
          sj <= '0;
          if (!s_rd[8] && !last_slot) sj <= sj + 1'b1;
          else ri <= ri + 1'b1;
        end
      end
      gnre_pkg::S_REB_WR: begin
        if (32'(f_rd) >= MAX_IN) over <= 1'b1;
        if (last_slot) begin sj <= '0; ri <= ri + 1'b1; end
        else sj <= sj + 1'b1;
      end
      gnre_pkg::S_SC_ACC: begin
        if (!sc_v[8])
          sum <= (sc_add > 22'(gnre_pkg::SCORE_MAX)) ? 21'(gnre_pkg::SCORE_MAX) : sc_add[20:0];
        if (sc_end_list) begin
          sj <= '0;
          lab_phase <= !lab_phase;
          if (lab_phase) ri <= ri + 1'b1;
        end else sj <= sj + 1'b1;
      end
      gnre_pkg::S_DONE: begin
        if (cmd_q == gnre_pkg::CMD_MOVE && st_res == gnre_pkg::ST_OK && over)
          st_res <= gnre_pkg::ST_OVER;
      end
      default: ;
    endcase
  end

  // result outputs
  logic is_rd;
  assign is_rd = (cmd_q == gnre_pkg::CMD_READ) && (st_res == gnre_pkg::ST_OK);
  assign status = st_res;
  assign score_sum = (cmd_q == gnre_pkg::CMD_SCORE) ? sum : 21'd0;
  assign edge_target = is_rd ? rd_tgt : 8'd0;
  assign edge_empty = is_rd ? rd_empty : 1'b0;
  assign row_label = is_rd ? rd_label : 8'd0;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_busy_nostart: assert property (@(posedge clk) disable iff (rst)
    (state == gnre_pkg::S_DONE) |=> (state == gnre_pkg::S_IDLE))
    else $error("done state stuck");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst) cfg_ready |-> !busy)
    else $error("cfg while busy");

endmodule

// ===== dv/graph_node_relocation_engine_top_tb.sv =====
`timescale 1ns / 1ps

module graph_node_relocation_engine_top_tb;

  localparam int NPOS = 256;
  localparam int NOUT = 8;
  localparam int NIN = 8;
  localparam logic [8:0] NO_EDGE = 9'h100;
  localparam int STALL_LIMIT = 400000;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] row;
    logic [2:0] slot;
    logic [7:0] target;
    logic       empty_slot;
    logic [7:0] label;
    logic [7:0] pos_a;
    logic [7:0] pos_b;
  } command_t;

  localparam int CMD_BITS = $bits(command_t);

  typedef struct packed {
    logic [1:0]  status;
    logic [20:0] score_sum;
    logic [7:0]  edge_target;
    logic        edge_empty;
    logic [7:0]  row_label;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  cmd = '0;
  logic [7:0]  row = '0;
  logic [2:0]  slot = '0;
  logic [7:0]  target = '0;
  logic        empty_slot = 1'b0;
  logic [7:0]  label = '0;
  logic [7:0]  pos_a = '0;
  logic [7:0]  pos_b = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;
  logic        done;
  logic [1:0]  status;
  logic [20:0] score_sum;
  logic [7:0]  edge_target;
  logic        edge_empty;
  logic [7:0]  row_label;

  graph_node_relocation_engine_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .row(row), .slot(slot), .target(target),
    .empty_slot(empty_slot), .label(label), .pos_a(pos_a), .pos_b(pos_b),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .status(status), .score_sum(score_sum),
    .edge_target(edge_target), .edge_empty(edge_empty), .row_label(row_label)
  );

  always #6 clk = ~clk;

  // Shadow copy of the placed graph
  logic [8:0] succ_sh [NPOS][NOUT];
  logic [8:0] pred_sh [NPOS][NIN];
  logic [7:0] label_sh [NPOS];
  bit         label_set [NPOS];
  int         fanin_sh [NPOS];
  logic [8:0] npos_sh;

  command_t   pending_cmds[$];
  answer_t    expected_answers[$];
  int         send_idle_pct = 16;
  int         mismatches = 0;
  int         stall_cycles = 0;

  function automatic int unsigned active_positions();
    int unsigned n;
    n = npos_sh;
    if (n == 0) n = 1;
    if (n > NPOS) n = NPOS;
    return n;
  endfunction

  // Rebuild predecessor rows from the successor lists; report fan-in overflow
  function automatic bit rebuild_preds(int unsigned n);
    bit over;
    int unsigned t;
    over = 1'b0;
    for (int i = 0; i < NPOS; i++) begin
      for (int j = 0; j < NIN; j++) pred_sh[i][j] = NO_EDGE;
      fanin_sh[i] = 0;
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < NOUT; j++) begin
        if (succ_sh[i][j][8]) break;
        t = succ_sh[i][j];
        if (t >= n) continue;
        if (fanin_sh[t] >= NIN) begin
          over = 1'b1;
          continue;
        end
        pred_sh[t][fanin_sh[t]] = 9'(i);
        fanin_sh[t]++;
      end
    end
    return over;
  endfunction

  function automatic bit relocate(int unsigned from, int unsigned to, int unsigned n);
    logic [8:0] held [NOUT];
    logic [7:0] held_label;
    bit         held_set;
    int unsigned t;
    // renumber every successor reference
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < NOUT; j++) begin
        if (succ_sh[i][j][8]) break;
        t = succ_sh[i][j];
        if (t == from) t = to;
        else if (from < to && t > from && t <= to) t--;
        else if (to < from && t >= to && t < from) t++;
        succ_sh[i][j] = 9'(t);
      end
    end
    // rotate rows and labels between the two positions
    held = succ_sh[from];
    held_label = label_sh[from];
    held_set = label_set[from];
    if (from < to) begin
      for (int i = from; i < to; i++) begin
        succ_sh[i] = succ_sh[i+1];
        label_sh[i] = label_sh[i+1];
        label_set[i] = label_set[i+1];
      end
    end else begin
      for (int i = from; i > to; i--) begin
        succ_sh[i] = succ_sh[i-1];
        label_sh[i] = label_sh[i-1];
        label_set[i] = label_set[i-1];
      end
    end
    succ_sh[to] = held;
    label_sh[to] = held_label;
    label_set[to] = held_set;
    return rebuild_preds(n);
  endfunction

  function automatic logic [20:0] range_distance(int unsigned a, int unsigned b);
    int unsigned lo, hi, sum, d, t;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    sum = 0;
    for (int unsigned i = lo; i <= hi; i++) begin
      for (int j = 0; j < NOUT; j++) begin
        if (succ_sh[i][j][8]) break;
        t = succ_sh[i][j];
        d = (t > i) ? t - i : i - t;
        sum = (sum + d > gnre_pkg::SCORE_MAX) ? gnre_pkg::SCORE_MAX : sum + d;
      end
      for (int j = 0; j < NIN; j++) begin
        if (pred_sh[i][j][8]) break;
        t = pred_sh[i][j];
        d = (t > i) ? t - i : i - t;
        sum = (sum + d > gnre_pkg::SCORE_MAX) ? gnre_pkg::SCORE_MAX : sum + d;
      end
    end
    return 21'(sum);
  endfunction

  // Apply one command to the shadow graph and return the answer it must give
  function automatic answer_t apply_command(command_t c);
    answer_t     a;
    int unsigned n;
    n = active_positions();
    a = '0;
    a.status = gnre_pkg::ST_OK;
    case (c.cmd)
      gnre_pkg::CMD_WR_EDGE: begin
        if (c.row >= n || (!c.empty_slot && c.target >= n)) a.status = gnre_pkg::ST_OOR;
        else succ_sh[c.row][c.slot] = c.empty_slot ? NO_EDGE : {1'b0, c.target};
      end
      gnre_pkg::CMD_WR_LABEL: begin
        if (c.row >= n) a.status = gnre_pkg::ST_OOR;
        else begin
          label_sh[c.row] = c.label;
          label_set[c.row] = 1'b1;
        end
      end
      gnre_pkg::CMD_MOVE: begin
        if (c.pos_a >= n || c.pos_b >= n) a.status = gnre_pkg::ST_OOR;
        else if (relocate(c.pos_a, c.pos_b, n)) a.status = gnre_pkg::ST_OVER;
      end
      gnre_pkg::CMD_SCORE: begin
        if (c.pos_a >= n || c.pos_b >= n) a.status = gnre_pkg::ST_OOR;
        else a.score_sum = range_distance(c.pos_a, c.pos_b);
      end
      gnre_pkg::CMD_READ: begin
        if (c.row >= n) a.status = gnre_pkg::ST_OOR;
        else begin
          if (succ_sh[c.row][c.slot][8]) a.edge_empty = 1'b1;
          else a.edge_target = succ_sh[c.row][c.slot][7:0];
          a.row_label = label_sh[c.row];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Queue a command with its answer; a read of a never-labeled row becomes a label write
  task automatic issue(command_t c);
    if (c.cmd == gnre_pkg::CMD_READ && c.row < active_positions() && !label_set[c.row])
      c.cmd = gnre_pkg::CMD_WR_LABEL;
    expected_answers.insert(expected_answers.size(), apply_command(c));
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  function automatic command_t mk(logic [2:0] op, logic [7:0] r, logic [2:0] s,
                                  logic [7:0] t, logic e, logic [7:0] l,
                                  logic [7:0] a, logic [7:0] b);
    command_t c;
    c = '{op, r, s, t, e, l, a, b};
    return c;
  endfunction

  function automatic logic [7:0] pick_pos(int unsigned n);
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, n - 1));
    return 8'($urandom);
  endfunction

  function automatic command_t random_command();
    command_t    c;
    int unsigned n, w;
    n = active_positions();
    c = command_t'(CMD_BITS'({$urandom, $urandom}));
    c.row = pick_pos(n);
    c.pos_a = pick_pos(n);
    c.pos_b = pick_pos(n);
    w = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 50) c.target = 8'($urandom_range(0, (n < 4) ? n - 1 : 3));
    else c.target = pick_pos(n);
    c.empty_slot = ($urandom_range(0, 99) < 15);
    if (w < 32) c.cmd = gnre_pkg::CMD_WR_EDGE;
    else if (w < 50) c.cmd = gnre_pkg::CMD_WR_LABEL;
    else if (w < 60) c.cmd = gnre_pkg::CMD_MOVE;
    else if (w < 70) c.cmd = gnre_pkg::CMD_SCORE;
    else if (w < 95) c.cmd = gnre_pkg::CMD_READ;
    else c.cmd = 3'($urandom_range(5, 7));
    return c;
  endfunction

  task automatic drain();
    while (pending_cmds.size() != 0 || start || expected_answers.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_positions(logic [8:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    npos_sh = v;
  endtask

  // Driver: present the next pending command, advance on each transfer
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        command_t c;
        c = pending_cmds.pop_front();
        {cmd, row, slot, target, empty_slot, label, pos_a, pos_b} <= c;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest expected answer
  always @(posedge clk) begin
    if (!rst && done) begin
      answer_t got, want;
      got = '{status, score_sum, edge_target, edge_empty, row_label};
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_answers.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: status %0d/%0d sum %0d/%0d tgt %0d/%0d",
                      " empty %0d/%0d lbl %0d/%0d"},
                     want.status, got.status, want.score_sum, got.score_sum,
                     want.edge_target, got.edge_target, want.edge_empty, got.edge_empty,
                     want.row_label, got.row_label);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [8:0] cfg_plan [8];
    cfg_plan = '{9'd256, 9'd16, 9'd0, 9'd511, 9'd1, 9'd255, 9'd300, 9'd40};
    for (int i = 0; i < NPOS; i++) begin
      for (int j = 0; j < NOUT; j++) succ_sh[i][j] = NO_EDGE;
      for (int j = 0; j < NIN; j++) pred_sh[i][j] = NO_EDGE;
      label_sh[i] = '0;
      label_set[i] = 1'b0;
      fanin_sh[i] = 0;
    end
    npos_sh = 9'd256;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, fan-in overflow, move in place, unused codes
    issue(mk(gnre_pkg::CMD_WR_LABEL, 8'd0, 3'd0, 8'd0, 1'b0, 8'hAA, 8'd0, 8'd0));
    issue(mk(gnre_pkg::CMD_WR_LABEL, 8'd255, 3'd7, 8'd255, 1'b1, 8'h55, 8'd255, 8'd255));
    issue(mk(gnre_pkg::CMD_WR_EDGE, 8'd0, 3'd0, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0));
    issue(mk(gnre_pkg::CMD_WR_EDGE, 8'd255, 3'd7, 8'd0, 1'b0, 8'hFF, 8'd0, 8'd0));
    issue(mk(gnre_pkg::CMD_WR_EDGE, 8'd255, 3'd0, 8'd170, 1'b0, 8'd0, 8'd0, 8'd0));
    issue(mk(gnre_pkg::CMD_READ, 8'd0, 3'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0));
    issue(mk(gnre_pkg::CMD_READ, 8'd0, 3'd1, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0));
    issue(mk(gnre_pkg::CMD_READ, 8'd255, 3'd7, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0));
    for (int k = 2; k <= 11; k++)
      issue(mk(gnre_pkg::CMD_WR_EDGE, 8'(k), 3'd0, 8'd1, 1'b0, 8'd0, 8'd0, 8'd0));
    issue(mk(gnre_pkg::CMD_MOVE, 8'd0, 3'd0, 8'd0, 1'b0, 8'd0, 8'd11, 8'd3));
    issue(mk(gnre_pkg::CMD_MOVE, 8'd0, 3'd0, 8'd0, 1'b0, 8'd0, 8'd5, 8'd5));
    issue(mk(gnre_pkg::CMD_MOVE, 8'd0, 3'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd255));
    issue(mk(gnre_pkg::CMD_SCORE, 8'd0, 3'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd255));
    issue(mk(gnre_pkg::CMD_SCORE, 8'd0, 3'd0, 8'd0, 1'b0, 8'd0, 8'd255, 8'd0));
    issue(mk(gnre_pkg::CMD_READ, 8'd255, 3'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0));
    for (int k = 5; k <= 7; k++)
      issue(mk(3'(k), 8'd255, 3'd7, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255));
    drain();

    // Random phases across register settings and idle profiles
    for (int p = 0; p < 8; p++) begin
      send_idle_pct = (p < 3) ? 16 : (p < 6) ? 79 : 0;
      write_positions(cfg_plan[p]);
      for (int k = 0; k < 14; k++) begin
        issue(random_command());
        // hold the sender until the block has answered everything
        if (p == 3 && k == 8) drain();
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/gnre_pkg.sv
hdl/gnre_ram.sv
hdl/graph_node_relocation_engine_top.sv
dv/graph_node_relocation_engine_top_tb.sv
